// ===== rtl/scrb_pkg.sv =====
`default_nettype none

package scrb_pkg;

   localparam int OPCODE_W   = 3;
   localparam int TIME_W     = 64;
   localparam int CAP_W      = 5;
   localparam int BOFF_W     = 4;
   localparam int SIDX_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd0;
   localparam logic [BOFF_W-1:0] BOFF_RESET = 4'd6;
   localparam logic [SIDX_W-1:0] SIDX_RESET = 5'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_INDEX    = 2'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_WAKEUP  = 3'd2,
      OP_HIT_ADD = 3'd3,
      OP_TICK    = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REMOVE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic exec;
      logic remove;
      logic scan_fire;
      logic scan_skip;
      logic load_rsp;
   } scrb_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                found;
      logic                scan_end;
      logic                hit_due;
   } scrb_status_type;

   function automatic int cnt_width(input int depth);
      return $clog2(depth + 1);
   endfunction

   function automatic int free_width(input int depth);
      int c;
      c = $clog2(depth + 1);
      return ((c > CAP_W) ? c : CAP_W) + 1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/scrb_ifs.sv =====
`default_nettype none

interface scrb_req_if #(
   parameter int ADDR_BITS = 48,
   parameter int ID_BITS   = 8
) ();
   import scrb_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [ADDR_BITS-1:0] addr;
   logic [ID_BITS-1:0]   packet_id;
   logic                 mshr_conflict;
   logic [TIME_W-1:0]    due_time;
   logic [TIME_W-1:0]    now;

   modport source (
      output valid, opcode, addr, packet_id, mshr_conflict, due_time, now,
      input  ready
   );
   modport sink (
      input  valid, opcode, addr, packet_id, mshr_conflict, due_time, now,
      output ready
   );
endinterface

interface scrb_rsp_if #(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 48,
   parameter int ID_BITS   = 8
) ();
   import scrb_pkg::*;

   localparam int CNT_W  = cnt_width(DEPTH);
   localparam int FREE_W = free_width(DEPTH);

   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic                     out_valid;
   logic [ID_BITS-1:0]       out_packet_id;
   logic [ADDR_BITS-1:0]     out_addr;
   logic [CNT_W-1:0]         busy_count;
   logic signed [FREE_W-1:0] free_count;
   logic [CNT_W-1:0]         ready_count;
   logic                     is_full;
   logic                     is_empty;

   modport source (
      output valid, accepted, out_valid, out_packet_id, out_addr, busy_count,
             free_count, ready_count, is_full, is_empty,
      input  ready
   );
   modport sink (
      input  valid, accepted, out_valid, out_packet_id, out_addr, busy_count,
             free_count, ready_count, is_full, is_empty,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/scrb_ctrl.sv =====
`default_nettype none

module scrb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  scrb_pkg::scrb_status_type status,
   output scrb_pkg::scrb_cmd_type    cmd
);
   import scrb_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      accept;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.opcode == OP_DEQUEUE) begin
               state_in = status.found ? ST_REMOVE : ST_FINISH;
            end else if (status.opcode == OP_TICK) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_REMOVE: begin
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (status.scan_end) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.latch_req = accept;
      cmd.exec      = (state_ff == ST_EXEC);
      cmd.remove    = (state_ff == ST_REMOVE);
      cmd.scan_fire = (state_ff == ST_SCAN) && !status.scan_end && status.hit_due;
      cmd.scan_skip = (state_ff == ST_SCAN) && !status.scan_end && !status.hit_due;
      cmd.load_rsp  = (state_ff == ST_FINISH) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/scrb_datapath.sv =====
`default_nettype none

module scrb_datapath #(
   parameter  int DEPTH     = 16,
   parameter  int HIT_DEPTH = 8,
   parameter  int ADDR_BITS = 48,
   parameter  int ID_BITS   = 8,
   localparam int CNT_W     = scrb_pkg::cnt_width(DEPTH),
   localparam int FREE_W    = scrb_pkg::free_width(DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [scrb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scrb_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [scrb_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [ADDR_BITS-1:0]                req_addr,
   input  logic [ID_BITS-1:0]                  req_packet_id,
   input  logic                                req_mshr_conflict,
   input  logic [scrb_pkg::TIME_W-1:0]         req_due_time,
   input  logic [scrb_pkg::TIME_W-1:0]         req_now,
   input  scrb_pkg::scrb_cmd_type              cmd,
   output scrb_pkg::scrb_status_type           status,
   output logic                                rsp_accepted,
   output logic                                rsp_out_valid,
   output logic [ID_BITS-1:0]                  rsp_out_packet_id,
   output logic [ADDR_BITS-1:0]                rsp_out_addr,
   output logic [CNT_W-1:0]                    rsp_busy_count,
   output logic signed [FREE_W-1:0]            rsp_free_count,
   output logic [CNT_W-1:0]                    rsp_ready_count,
   output logic                                rsp_is_full,
   output logic                                rsp_is_empty
);
   import scrb_pkg::*;

   localparam int ENT_IDX_W = $clog2(DEPTH);
   localparam int HIT_CNT_W = $clog2(HIT_DEPTH + 1);
   localparam int HIT_IDX_W = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // configuration
   logic [CAP_W-1:0]  capacity_ff;
   logic [BOFF_W-1:0] boff_ff;
   logic [SIDX_W-1:0] sidx_ff;

   // captured request
   logic [OPCODE_W-1:0]  op_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic                 conflict_ff;
   logic [TIME_W-1:0]    due_ff;
   logic [TIME_W-1:0]    now_ff;

   // request queue, oldest in slot 0
   logic [ADDR_BITS-1:0] ent_addr_ff [DEPTH];
   logic [ID_BITS-1:0]   ent_id_ff [DEPTH];
   logic [DEPTH-1:0]     ent_blocked_ff;
   logic [DEPTH-1:0]     ent_blocked_in;
   logic [CNT_W-1:0]     busy_ff;

   // hit queue
   logic [ADDR_BITS-1:0] hit_addr_ff [HIT_DEPTH];
   logic [TIME_W-1:0]    hit_due_ff [HIT_DEPTH];
   logic [HIT_CNT_W-1:0] hits_ff;
   logic [HIT_CNT_W-1:0] scan_idx_ff;

   // dequeue selection and per-item results
   logic [ENT_IDX_W-1:0] sel_idx_ff;
   logic                 acc_ff;
   logic                 res_valid_ff;
   logic [ID_BITS-1:0]   res_id_ff;
   logic [ADDR_BITS-1:0] res_addr_ff;

   logic [TIME_W-1:0]    mask_wide;
   logic [ADDR_BITS-1:0] set_mask;
   logic [DEPTH-1:0]     ent_live;
   logic [DEPTH-1:0]     ready_vec;
   logic [DEPTH-1:0]     match;
   logic [DEPTH-1:0]     blocked_woken;
   logic [ADDR_BITS-1:0] wake_key;
   logic                 wake_en;
   logic                 sel_any;
   logic [ENT_IDX_W-1:0] sel_idx;
   logic                 ent_full;
   logic                 hit_full;
   logic                 enq_fire;
   logic                 hit_fire;
   logic                 is_op_exec_wake;
   logic [ENT_IDX_W-1:0] enq_slot;
   logic [HIT_IDX_W-1:0] hit_slot;
   logic [HIT_IDX_W-1:0] scan_slot;
   logic                 scan_end;
   logic                 hit_due;
   logic [CNT_W-1:0]     ready_cnt;
   logic [FREE_W-1:0]    free_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         boff_ff     <= BOFF_RESET;
         sidx_ff     <= SIDX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CAPACITY:     capacity_ff <= csr_write_data[CAP_W-1:0];
            CSR_BLOCK_OFFSET: boff_ff     <= csr_write_data[BOFF_W-1:0];
            CSR_SET_INDEX:    sidx_ff     <= csr_write_data[SIDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff       <= req_opcode;
         addr_ff     <= req_addr;
         id_ff       <= req_packet_id;
         conflict_ff <= req_mshr_conflict;
         due_ff      <= req_due_time;
         now_ff      <= req_now;
      end
   end

   // set compare done in address space: set bits of both addresses must agree
   assign mask_wide = ((TIME_W'(1) << sidx_ff) - TIME_W'(1)) << boff_ff;
   assign set_mask  = mask_wide[ADDR_BITS-1:0];

   assign scan_slot = scan_idx_ff[HIT_IDX_W-1:0];
   assign scan_end  = (scan_idx_ff >= hits_ff);
   assign hit_due   = (hit_due_ff[scan_slot] <= now_ff);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_live[i] = (CNT_W'(i) < busy_ff);
      end
   end

   assign ready_vec = ent_live & ~ent_blocked_ff;
   assign sel_any   = |ready_vec;

   always_comb begin
      sel_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (ready_vec[i]) sel_idx = ENT_IDX_W'(i);
      end
   end

   assign is_op_exec_wake = cmd.exec && (op_ff == OP_WAKEUP);
   assign wake_en         = is_op_exec_wake || cmd.remove || cmd.scan_fire;

   always_comb begin
      priority if (cmd.remove) begin
         wake_key = res_addr_ff;
      end else if (cmd.scan_fire) begin
         wake_key = hit_addr_ff[scan_slot];
      end else begin
         wake_key = addr_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = ent_live[i] && (((ent_addr_ff[i] ^ wake_key) & set_mask) == '0);
      end
   end

   assign blocked_woken = ent_blocked_ff & ~(match & {DEPTH{wake_en}});

   assign ent_full = ((capacity_ff != '0) && (CMP_W'(busy_ff) >= CMP_W'(capacity_ff)))
                     || (busy_ff >= CNT_W'(DEPTH));
   assign hit_full = (hits_ff >= HIT_CNT_W'(HIT_DEPTH));
   assign enq_fire = cmd.exec && (op_ff == OP_ENQUEUE) && !ent_full;
   assign hit_fire = cmd.exec && (op_ff == OP_HIT_ADD) && !hit_full;
   assign enq_slot = busy_ff[ENT_IDX_W-1:0];
   assign hit_slot = hits_ff[HIT_IDX_W-1:0];

   // wake first, then close the gap left by the removed entry
   always_comb begin
      ent_blocked_in = blocked_woken;
      if (cmd.remove) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (ENT_IDX_W'(i) >= sel_idx_ff) ent_blocked_in[i] = blocked_woken[i + 1];
         end
      end
      if (enq_fire) ent_blocked_in[enq_slot] = conflict_ff;
   end

   always_ff @(posedge clock) begin
      ent_blocked_ff <= ent_blocked_in;
      if (enq_fire) begin
         ent_addr_ff[enq_slot] <= addr_ff;
         ent_id_ff[enq_slot]   <= id_ff;
      end
      if (cmd.remove) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (ENT_IDX_W'(i) >= sel_idx_ff) begin
               ent_addr_ff[i] <= ent_addr_ff[i + 1];
               ent_id_ff[i]   <= ent_id_ff[i + 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (enq_fire) begin
         busy_ff <= busy_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         busy_ff <= busy_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (hit_fire) begin
         hit_addr_ff[hit_slot] <= addr_ff;
         hit_due_ff[hit_slot]  <= due_ff;
      end
      if (cmd.scan_fire) begin
         for (int i = 0; i < HIT_DEPTH - 1; i++) begin
            if (HIT_IDX_W'(i) >= scan_slot) begin
               hit_addr_ff[i] <= hit_addr_ff[i + 1];
               hit_due_ff[i]  <= hit_due_ff[i + 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff     <= '0;
         scan_idx_ff <= '0;
      end else begin
         if (hit_fire) begin
            hits_ff <= hits_ff + HIT_CNT_W'(1);
         end else if (cmd.scan_fire) begin
            hits_ff <= hits_ff - HIT_CNT_W'(1);
         end
         // a fired slot is refilled by the shift, so the scan stays put
         if (cmd.exec) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_skip) begin
            scan_idx_ff <= scan_idx_ff + HIT_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         acc_ff       <= 1'b0;
         res_valid_ff <= 1'b0;
         res_id_ff    <= '0;
         res_addr_ff  <= '0;
      end else if (cmd.exec) begin
         acc_ff <= enq_fire || hit_fire;
         if ((op_ff == OP_DEQUEUE) && sel_any) begin
            res_valid_ff <= 1'b1;
            res_id_ff    <= ent_id_ff[sel_idx];
            res_addr_ff  <= ent_addr_ff[sel_idx];
         end
         sel_idx_ff <= sel_idx;
      end
   end

   always_comb begin
      ready_cnt = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ready_cnt = ready_cnt + CNT_W'(ready_vec[i]);
      end
   end

   always_comb begin
      priority if (capacity_ff == '0) begin
         free_val = '1;
      end else if (CMP_W'(capacity_ff) <= CMP_W'(busy_ff)) begin
         free_val = '0;
      end else begin
         free_val = FREE_W'(capacity_ff) - FREE_W'(busy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_accepted      <= acc_ff;
         rsp_out_valid     <= res_valid_ff;
         rsp_out_packet_id <= res_id_ff;
         rsp_out_addr      <= res_addr_ff;
         rsp_busy_count    <= busy_ff;
         rsp_free_count    <= free_val;
         rsp_ready_count   <= ready_cnt;
         rsp_is_full       <= (free_val == '0);
         rsp_is_empty      <= (busy_ff == '0);
      end
   end

   always_comb begin
      status          = '0;
      status.opcode   = op_ff;
      status.found    = sel_any;
      status.scan_end = scan_end;
      status.hit_due  = hit_due;
   end

endmodule

`default_nettype wire

// ===== rtl/set_conflict_request_buffer.sv =====
`default_nettype none

// Ordered request buffer with set-conflict blocking and a timed hit queue. Each
// beat on req_bus carries one operation (enqueue, dequeue, MSHR wakeup, hit add,
// tick) and yields exactly one beat on rsp_bus with the counts after the step.
// Work runs through a small sequencer: enqueue, wakeup, hit add, a dequeue that
// finds nothing and unused opcodes pass through the execute and finish steps, a
// dequeue that finds an entry adds a remove step between them, and a tick adds
// the hit-queue scan, which visits or fires one slot per cycle until it has
// passed every hit waiting. Set matching against all held entries is done in
// parallel. A finished result sits in the output register, so the next beat
// can be taken while rsp_bus is stalled. Configuration is to be written
// through csr_* only while the block is idle; the user is bound by this, as
// the block itself does not enforce it.
module set_conflict_request_buffer #(
   parameter int DEPTH     = 16,
   parameter int HIT_DEPTH = 8,
   parameter int ADDR_BITS = 48,
   parameter int ID_BITS   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [scrb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scrb_pkg::CSR_DATA_W-1:0] csr_write_data,
   scrb_req_if.sink                        req_bus,
   scrb_rsp_if.source                      rsp_bus
);
   import scrb_pkg::*;

   scrb_cmd_type    cmd;
   scrb_status_type status;

   scrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scrb_datapath #(
      .DEPTH     (DEPTH),
      .HIT_DEPTH (HIT_DEPTH),
      .ADDR_BITS (ADDR_BITS),
      .ID_BITS   (ID_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_opcode        (req_bus.opcode),
      .req_addr          (req_bus.addr),
      .req_packet_id     (req_bus.packet_id),
      .req_mshr_conflict (req_bus.mshr_conflict),
      .req_due_time      (req_bus.due_time),
      .req_now           (req_bus.now),
      .cmd               (cmd),
      .status            (status),
      .rsp_accepted      (rsp_bus.accepted),
      .rsp_out_valid     (rsp_bus.out_valid),
      .rsp_out_packet_id (rsp_bus.out_packet_id),
      .rsp_out_addr      (rsp_bus.out_addr),
      .rsp_busy_count    (rsp_bus.busy_count),
      .rsp_free_count    (rsp_bus.free_count),
      .rsp_ready_count   (rsp_bus.ready_count),
      .rsp_is_full       (rsp_bus.is_full),
      .rsp_is_empty      (rsp_bus.is_empty)
   );

endmodule

`default_nettype wire

// ===== rtl/scrb_checker.sv =====
`default_nettype none

module scrb_checker #(
   parameter  int DEPTH     = 16,
   parameter  int ADDR_BITS = 48,
   parameter  int ID_BITS   = 8,
   localparam int CNT_W     = scrb_pkg::cnt_width(DEPTH),
   localparam int FREE_W    = scrb_pkg::free_width(DEPTH)
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     accepted,
   input logic                     out_valid,
   input logic [ID_BITS-1:0]       out_packet_id,
   input logic [ADDR_BITS-1:0]     out_addr,
   input logic [CNT_W-1:0]         busy_count,
   input logic signed [FREE_W-1:0] free_count,
   input logic [CNT_W-1:0]         ready_count,
   input logic                     is_full,
   input logic                     is_empty
);

   // stalled result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({accepted, out_valid, out_packet_id, out_addr, busy_count,
                     free_count, ready_count, is_full, is_empty}))
      else $error("result beat changed while stalled");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(accepted && out_valid))
      else $error("result both stored and dequeued");

   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !out_valid |-> (out_packet_id == '0) && (out_addr == '0))
      else $error("dequeue fields not cleared without an entry");

   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ready_count <= busy_count) && (is_empty == (busy_count == '0))
                    && (is_full == (free_count == '0)))
      else $error("inconsistent counts in result");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

endmodule

bind set_conflict_request_buffer scrb_checker #(
   .DEPTH     (DEPTH),
   .ADDR_BITS (ADDR_BITS),
   .ID_BITS   (ID_BITS)
) u_scrb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .accepted      (rsp_bus.accepted),
   .out_valid     (rsp_bus.out_valid),
   .out_packet_id (rsp_bus.out_packet_id),
   .out_addr      (rsp_bus.out_addr),
   .busy_count    (rsp_bus.busy_count),
   .free_count    (rsp_bus.free_count),
   .ready_count   (rsp_bus.ready_count),
   .is_full       (rsp_bus.is_full),
   .is_empty      (rsp_bus.is_empty)
);

`default_nettype wire
